// ----- rtl/core/lobm_pkg.sv -----
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and codes for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int QTY_BITS = 31;
    localparam logic [QTY_BITS-1:0] QTY_MAX = '1;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_TRADE  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_MATCH = 1'b1;
    localparam logic SIDE_BID   = 1'b1;

    typedef struct packed {
        logic        func;
        logic        side;
        logic [31:0] price;
        logic [30:0] quantity;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] trade_quantity;
        logic [31:0] trade_price;
        logic        best_bid_valid;
        logic [31:0] best_bid;
        logic        best_ask_valid;
        logic [31:0] best_ask;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_EVAL,
        ST_TRADE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic do_add;
        logic scan;
        logic do_trade;
        logic emit;
        logic last;
        kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic is_match;
        logic add_ok;
        logic scan_done;
        logic crossed;
        logic trade_limit;
    } sts_t;

endpackage

// ----- rtl/core/lobm_ctrl.sv -----
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer for add and match transactions.
// ----------------------------------------------------------------------------
module lobm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  lobm_pkg::sts_t  sts,
    output lobm_pkg::cmd_t  cmd
);

    lobm_pkg::state_t state_reg, state_next;
    logic             traded_reg, traded_next;
    logic             rej_reg, rej_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lobm_pkg::ST_IDLE;
            traded_reg <= 1'b0;
            rej_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            traded_reg <= traded_next;
            rej_reg    <= rej_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        traded_next = traded_reg;
        rej_next    = rej_reg;
        case (state_reg)
            lobm_pkg::ST_IDLE:
            begin
                traded_next = 1'b0;
                rej_next    = 1'b0;
                if (start)
                    state_next = lobm_pkg::ST_ADD;
            end
            lobm_pkg::ST_ADD:
            begin
                rej_next   = !sts.is_match && !sts.add_ok;
                state_next = lobm_pkg::ST_SCAN;
            end
            lobm_pkg::ST_SCAN:
                if (sts.scan_done)
                    state_next = sts.is_match ? lobm_pkg::ST_EVAL : lobm_pkg::ST_DONE;
            lobm_pkg::ST_EVAL:
                if (sts.crossed && !sts.trade_limit)
                    state_next = lobm_pkg::ST_TRADE;
                else if (traded_reg)
                    state_next = lobm_pkg::ST_IDLE;
                else
                    state_next = lobm_pkg::ST_DONE;
            lobm_pkg::ST_TRADE:
            begin
                traded_next = 1'b1;
                state_next  = lobm_pkg::ST_SCAN;
            end
            lobm_pkg::ST_DONE:
                state_next = lobm_pkg::ST_IDLE;
            default:
                state_next = lobm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.kind = lobm_pkg::KIND_STATUS;
        busy     = (state_reg != lobm_pkg::ST_IDLE);
        case (state_reg)
            lobm_pkg::ST_IDLE:
                cmd.load = start;
            lobm_pkg::ST_ADD:
            begin
                cmd.do_add = !sts.is_match;
                cmd.scan   = sts.is_match;
            end
            lobm_pkg::ST_SCAN:
                cmd.scan = !sts.scan_done;
            lobm_pkg::ST_EVAL:
                if (traded_reg && !(sts.crossed && !sts.trade_limit))
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    cmd.kind = lobm_pkg::KIND_TRADE;
                end
                else if (traded_reg)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = lobm_pkg::KIND_TRADE;
                end
            lobm_pkg::ST_TRADE:
                cmd.do_trade = 1'b1;
            lobm_pkg::ST_DONE:
            begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                cmd.kind = rej_reg ? lobm_pkg::KIND_REJECT : lobm_pkg::KIND_STATUS;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

// ----- rtl/core/lobm_dp.sv -----
// ----------------------------------------------------------------------------
// lobm_dp
// Level storage, best-level scan, add and trade datapath.
// ----------------------------------------------------------------------------
module lobm_dp #(
    parameter int LEVELS     = 16,
    parameter int PRICE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lobm_pkg::in_item_t  in_item,
    input  lobm_pkg::cmd_t      cmd,
    output lobm_pkg::sts_t      sts,
    output logic                result_valid,
    output lobm_pkg::out_item_t result
);

    localparam int IDX_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CNT_BITS = $clog2(LEVELS + 1);
    localparam int TRD_BITS = $clog2(2 * LEVELS);
    localparam int QB       = lobm_pkg::QTY_BITS;

    logic [PRICE_BITS-1:0] bid_p_reg [LEVELS];
    logic [QB-1:0]         bid_q_reg [LEVELS];
    logic [LEVELS-1:0]     bid_v_reg;
    logic [PRICE_BITS-1:0] ask_p_reg [LEVELS];
    logic [QB-1:0]         ask_q_reg [LEVELS];
    logic [LEVELS-1:0]     ask_v_reg;

    lobm_pkg::in_item_t    item_reg;
    logic [CNT_BITS-1:0]   scan_reg;
    logic                  bb_v_reg, ba_v_reg;
    logic [IDX_BITS-1:0]   bb_i_reg, ba_i_reg;
    logic [TRD_BITS-1:0]   ntrade_reg;
    logic [QB-1:0]         tq_reg;
    logic [31:0]           tp_reg;
    logic                  result_valid_reg;
    lobm_pkg::out_item_t   result_reg;

    logic [PRICE_BITS-1:0] in_price;
    logic [IDX_BITS-1:0]   scan_idx;
    logic [LEVELS-1:0]     bid_hit, ask_hit;
    logic [LEVELS-1:0]     side_v, side_hit;
    logic                  any_hit, any_free;
    logic [IDX_BITS-1:0]   hit_idx, free_idx;
    logic                  is_bid;
    logic [QB:0]           sum;
    logic [QB-1:0]         sat_q, cur_q;
    logic [QB-1:0]         bq, aq, tq;
    logic                  crossed;

    assign in_price = PRICE_BITS'(item_reg.price);
    assign scan_idx = scan_reg[IDX_BITS-1:0];
    assign is_bid   = (item_reg.side == lobm_pkg::SIDE_BID);

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            bid_hit[i] = bid_v_reg[i] && (bid_p_reg[i] == in_price);
            ask_hit[i] = ask_v_reg[i] && (ask_p_reg[i] == in_price);
        end
        side_v   = is_bid ? bid_v_reg : ask_v_reg;
        side_hit = is_bid ? bid_hit : ask_hit;
        any_hit  = |side_hit;
        any_free = ~&side_v;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (side_hit[i])
                hit_idx = IDX_BITS'(i);
            if (!side_v[i])
                free_idx = IDX_BITS'(i);
        end
        cur_q = is_bid ? bid_q_reg[hit_idx] : ask_q_reg[hit_idx];
        sum   = {1'b0, cur_q} + {1'b0, item_reg.quantity};
        sat_q = sum[QB] ? lobm_pkg::QTY_MAX : sum[QB-1:0];
        bq    = bid_q_reg[bb_i_reg];
        aq    = ask_q_reg[ba_i_reg];
        tq    = (bq < aq) ? bq : aq;
        crossed = bb_v_reg && ba_v_reg && (bid_p_reg[bb_i_reg] >= ask_p_reg[ba_i_reg]);
    end

    assign sts.is_match    = (item_reg.func == lobm_pkg::FUNC_MATCH);
    assign sts.add_ok      = (item_reg.quantity == '0) || any_hit || any_free;
    assign sts.scan_done   = (scan_reg == CNT_BITS'(LEVELS));
    assign sts.crossed     = crossed;
    assign sts.trade_limit = (ntrade_reg == TRD_BITS'(2 * LEVELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_v_reg <= '0;
            ask_v_reg <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                bid_p_reg[i] <= '0;
                bid_q_reg[i] <= '0;
                ask_p_reg[i] <= '0;
                ask_q_reg[i] <= '0;
            end
            scan_reg         <= '0;
            ntrade_reg       <= '0;
            bb_v_reg         <= 1'b0;
            ba_v_reg         <= 1'b0;
            bb_i_reg         <= '0;
            ba_i_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
            if (cmd.load)
            begin
                ntrade_reg <= '0;
                scan_reg   <= '0;
            end
            if (cmd.do_add && item_reg.quantity != '0)
            begin
                if (any_hit)
                begin
                    if (is_bid) bid_q_reg[hit_idx] <= sat_q;
                    else        ask_q_reg[hit_idx] <= sat_q;
                end
                else if (any_free)
                begin
                    if (is_bid)
                    begin
                        bid_p_reg[free_idx] <= in_price;
                        bid_q_reg[free_idx] <= item_reg.quantity;
                        bid_v_reg[free_idx] <= 1'b1;
                    end
                    else
                    begin
                        ask_p_reg[free_idx] <= in_price;
                        ask_q_reg[free_idx] <= item_reg.quantity;
                        ask_v_reg[free_idx] <= 1'b1;
                    end
                end
            end
            if (cmd.scan)
            begin
                if (scan_reg == '0 || sts.scan_done)
                begin
                    bb_v_reg <= 1'b0;
                    ba_v_reg <= 1'b0;
                    scan_reg <= CNT_BITS'(1);
                    if (bid_v_reg[0]) begin bb_v_reg <= 1'b1; bb_i_reg <= '0; end
                    if (ask_v_reg[0]) begin ba_v_reg <= 1'b1; ba_i_reg <= '0; end
                end
                else
                begin
                    scan_reg <= scan_reg + CNT_BITS'(1);
                    if (bid_v_reg[scan_idx] &&
                        (!bb_v_reg || bid_p_reg[scan_idx] > bid_p_reg[bb_i_reg]))
                    begin
                        bb_v_reg <= 1'b1;
                        bb_i_reg <= scan_idx;
                    end
                    if (ask_v_reg[scan_idx] &&
                        (!ba_v_reg || ask_p_reg[scan_idx] < ask_p_reg[ba_i_reg]))
                    begin
                        ba_v_reg <= 1'b1;
                        ba_i_reg <= scan_idx;
                    end
                end
            end
            if (cmd.do_trade)
            begin
                ntrade_reg <= ntrade_reg + TRD_BITS'(1);
                scan_reg   <= '0;
                bid_q_reg[bb_i_reg] <= bq - tq;
                ask_q_reg[ba_i_reg] <= aq - tq;
                if (bq == tq)
                begin
                    bid_v_reg[bb_i_reg] <= 1'b0;
                    bid_p_reg[bb_i_reg] <= '0;
                end
                if (aq == tq)
                begin
                    ask_v_reg[ba_i_reg] <= 1'b0;
                    ask_p_reg[ba_i_reg] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.do_trade)
        begin
            tq_reg <= tq;
            tp_reg <= 32'(ask_p_reg[ba_i_reg]);
        end
    end

    // Every emit follows a full scan, so best prices come from the scan registers.
    logic                  rb_v, ra_v;
    logic [PRICE_BITS-1:0] rb_p, ra_p;

    assign rb_v = bb_v_reg;
    assign ra_v = ba_v_reg;
    assign rb_p = bb_v_reg ? bid_p_reg[bb_i_reg] : '0;
    assign ra_p = ba_v_reg ? ask_p_reg[ba_i_reg] : '0;

    logic [QB-1:0] unused_q;
    assign unused_q = '0;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.kind           <= cmd.kind;
            result_reg.trade_quantity <= (cmd.kind == lobm_pkg::KIND_TRADE) ? tq_reg : unused_q;
            result_reg.trade_price    <= (cmd.kind == lobm_pkg::KIND_TRADE) ? tp_reg : '0;
            result_reg.best_bid_valid <= rb_v;
            result_reg.best_bid       <= 32'(rb_p);
            result_reg.best_ask_valid <= ra_v;
            result_reg.best_ask       <= 32'(ra_p);
            result_reg.last           <= cmd.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/core/limit_order_book_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Two-sided price-level order book with a crossing matcher.
// ----------------------------------------------------------------------------
// Add: update, full best-level rescan of LEVELS slots, emit; a new add is taken
// only after the previous transaction has finished (busy low).
// Match: rescan and evaluate; with no cross a status result is emitted; each trade
// is an update, rescan and evaluate, and its result is emitted at that evaluate.
// Results are strobed by result_valid for one cycle; the receiver cannot stall.
// Reset (rst_n low, async) empties both books.
module limit_order_book_matcher_unit #(
    parameter int LEVELS     = 16,
    parameter int PRICE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lobm_pkg::in_item_t  in_item,
    output logic                result_valid,
    output lobm_pkg::out_item_t result
);

    lobm_pkg::cmd_t cmd;
    lobm_pkg::sts_t sts;

    lobm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    lobm_dp #(
        .LEVELS     (LEVELS),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- tb/sv/limit_order_book_matcher_unit_tb.sv -----
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit_tb
// Drives add and match commands into the order book matcher and compares
// every strobed result against a behavioral book model, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module limit_order_book_matcher_unit_tb;

    localparam int LEVELS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    class book_scoreboard;
        logic [31:0] bid_px [LEVELS];
        logic [30:0] bid_qty [LEVELS];
        bit          bid_ok [LEVELS];
        logic [31:0] ask_px [LEVELS];
        logic [30:0] ask_qty [LEVELS];
        bit          ask_ok [LEVELS];
        lobm_pkg::out_item_t pending_results[$];
        int          errors;

        function new();
            errors = 0;
            for (int i = 0; i < LEVELS; i++)
            begin
                bid_px[i] = '0; bid_qty[i] = '0; bid_ok[i] = 0;
                ask_px[i] = '0; ask_qty[i] = '0; ask_ok[i] = 0;
            end
        endfunction

        function int best_bid_slot();
            int b;
            b = -1;
            for (int i = 0; i < LEVELS; i++)
                if (bid_ok[i] && (b < 0 || bid_px[i] > bid_px[b]))
                    b = i;
            return b;
        endfunction

        function int best_ask_slot();
            int a;
            a = -1;
            for (int i = 0; i < LEVELS; i++)
                if (ask_ok[i] && (a < 0 || ask_px[i] < ask_px[a]))
                    a = i;
            return a;
        endfunction

        function lobm_pkg::out_item_t snapshot(lobm_pkg::kind_t k, logic [30:0] tq,
                                               logic [31:0] tp);
            lobm_pkg::out_item_t r;
            int b;
            int a;
            b = best_bid_slot();
            a = best_ask_slot();
            r = '0;
            r.kind = k;
            r.trade_quantity = tq;
            r.trade_price = tp;
            r.best_bid_valid = (b >= 0);
            r.best_bid = (b >= 0) ? bid_px[b] : '0;
            r.best_ask_valid = (a >= 0);
            r.best_ask = (a >= 0) ? ask_px[a] : '0;
            return r;
        endfunction

        function bit merge_level(bit is_bid, logic [31:0] px, logic [30:0] qty);
            int free_slot;
            logic [31:0] sum;
            free_slot = -1;
            if (qty == 0)
                return 1;
            for (int i = 0; i < LEVELS; i++)
            begin
                if (is_bid ? (bid_ok[i] && bid_px[i] == px) : (ask_ok[i] && ask_px[i] == px))
                begin
                    sum = (is_bid ? bid_qty[i] : ask_qty[i]) + qty;
                    if (sum > lobm_pkg::QTY_MAX)
                        sum = {1'b0, lobm_pkg::QTY_MAX};
                    if (is_bid) bid_qty[i] = sum[30:0];
                    else ask_qty[i] = sum[30:0];
                    return 1;
                end
                if (!(is_bid ? bid_ok[i] : ask_ok[i]) && free_slot < 0)
                    free_slot = i;
            end
            if (free_slot < 0)
                return 0;
            if (is_bid)
            begin
                bid_px[free_slot] = px; bid_qty[free_slot] = qty; bid_ok[free_slot] = 1;
            end
            else
            begin
                ask_px[free_slot] = px; ask_qty[free_slot] = qty; ask_ok[free_slot] = 1;
            end
            return 1;
        endfunction

        function void note_command(lobm_pkg::in_item_t cmd);
            lobm_pkg::out_item_t r;
            int n;
            int b;
            int a;
            logic [30:0] tq;
            logic [31:0] tp;
            if (cmd.func == lobm_pkg::FUNC_ADD)
            begin
                r = merge_level(cmd.side == lobm_pkg::SIDE_BID, cmd.price, cmd.quantity)
                    ? snapshot(lobm_pkg::KIND_STATUS, '0, '0)
                    : snapshot(lobm_pkg::KIND_REJECT, '0, '0);
                r.last = 1;
                pending_results.push_back(r);
                return;
            end
            n = 0;
            forever
            begin
                b = best_bid_slot();
                a = best_ask_slot();
                if (b < 0 || a < 0 || n >= 2 * LEVELS - 1)
                    break;
                if (bid_px[b] < ask_px[a])
                    break;
                tq = (bid_qty[b] < ask_qty[a]) ? bid_qty[b] : ask_qty[a];
                tp = ask_px[a];
                bid_qty[b] -= tq;
                ask_qty[a] -= tq;
                if (bid_qty[b] == 0)
                begin
                    bid_ok[b] = 0; bid_px[b] = '0;
                end
                if (ask_qty[a] == 0)
                begin
                    ask_ok[a] = 0; ask_px[a] = '0;
                end
                pending_results.push_back(snapshot(lobm_pkg::KIND_TRADE, tq, tp));
                n++;
            end
            if (n == 0)
                pending_results.push_back(snapshot(lobm_pkg::KIND_STATUS, '0, '0));
            r = pending_results.pop_back();
            r.last = 1;
            pending_results.push_back(r);
        endfunction

        function void check_result(lobm_pkg::out_item_t got);
            lobm_pkg::out_item_t exp;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.kind !== exp.kind)
                $display("%0t kind exp %0d got %0d", $time, exp.kind, got.kind);
            if (got.trade_quantity !== exp.trade_quantity)
                $display("%0t trade_quantity exp %0d got %0d", $time,
                         exp.trade_quantity, got.trade_quantity);
            if (got.trade_price !== exp.trade_price)
                $display("%0t trade_price exp %0d got %0d", $time,
                         exp.trade_price, got.trade_price);
            if (got.best_bid_valid !== exp.best_bid_valid)
                $display("%0t best_bid_valid exp %0d got %0d", $time,
                         exp.best_bid_valid, got.best_bid_valid);
            if (got.best_bid !== exp.best_bid)
                $display("%0t best_bid exp %0d got %0d", $time, exp.best_bid, got.best_bid);
            if (got.best_ask_valid !== exp.best_ask_valid)
                $display("%0t best_ask_valid exp %0d got %0d", $time,
                         exp.best_ask_valid, got.best_ask_valid);
            if (got.best_ask !== exp.best_ask)
                $display("%0t best_ask exp %0d got %0d", $time, exp.best_ask, got.best_ask);
            if (got.last !== exp.last)
                $display("%0t last exp %0d got %0d", $time, exp.last, got.last);
            if (got !== exp)
                errors++;
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    lobm_pkg::in_item_t  in_item;
    logic      result_valid;
    lobm_pkg::out_item_t result;

    book_scoreboard book;
    int        sender_idle_pct;
    int        quiet_cycles;
    bit        timed_out;
    logic [31:0] price_base;

    limit_order_book_matcher_unit #(.LEVELS(LEVELS), .PRICE_BITS(32)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .in_item(in_item),
        .result_valid(result_valid),
        .result(result)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            book.check_result(result);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Returns at the accepting edge; start stays high until the next call.
    task automatic send_command(logic f, logic s, logic [31:0] px, logic [30:0] qty);
        lobm_pkg::in_item_t cmd;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        cmd.func = f;
        cmd.side = s;
        cmd.price = px;
        cmd.quantity = qty;
        start <= 1'b1;
        in_item <= cmd;
        do
            @(posedge clk);
        while (busy);
        book.note_command(cmd);
    endtask

    task automatic random_command();
        int r;
        logic [30:0] qty;
        r = $urandom_range(99);
        case ($urandom_range(9))
            0: qty = 31'($urandom());
            1: qty = '0;
            default: qty = 31'($urandom_range(1, 200));
        endcase
        if (r < 12)
            send_command(lobm_pkg::FUNC_MATCH, 1'($urandom()), $urandom(), 31'($urandom()));
        else if (r < 17)
            send_command(lobm_pkg::FUNC_ADD, 1'($urandom()), $urandom(), qty);
        else
            send_command(lobm_pkg::FUNC_ADD, 1'($urandom()),
                         price_base + $urandom_range(0, 24), qty);
    endtask

    initial
    begin
        book = new();
        start = 1'b0;
        in_item = '0;
        rst_n = 1'b0;
        quiet_cycles = 0;
        timed_out = 0;
        sender_idle_pct = 0;
        price_base = 32'd1000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(lobm_pkg::FUNC_MATCH, 1'b0, '0, '0);
        send_command(lobm_pkg::FUNC_ADD, lobm_pkg::SIDE_BID, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_command(lobm_pkg::FUNC_ADD, lobm_pkg::SIDE_BID, 32'hFFFF_FFFF, 31'd5);
        send_command(lobm_pkg::FUNC_MATCH, 1'b1, '1, '1);
        send_command(lobm_pkg::FUNC_ADD, 1'b0, 32'd0, 31'd0);
        send_command(lobm_pkg::FUNC_ADD, 1'b0, 32'd0, 31'd7);
        send_command(lobm_pkg::FUNC_ADD, 1'b0, 32'd0, 31'h7FFF_FFFF);
        send_command(lobm_pkg::FUNC_MATCH, 1'b0, '0, '0);
        for (int i = 0; i < LEVELS; i++)
            send_command(lobm_pkg::FUNC_ADD, 1'b0, 32'd100 + i, 31'd3);
        send_command(lobm_pkg::FUNC_ADD, 1'b0, 32'd50, 31'd1);
        send_command(lobm_pkg::FUNC_ADD, lobm_pkg::SIDE_BID, 32'd90, 31'd1);
        send_command(lobm_pkg::FUNC_MATCH, 1'b0, '0, '0);
        for (int i = 0; i < LEVELS; i++)
            send_command(lobm_pkg::FUNC_ADD, lobm_pkg::SIDE_BID, 32'd200 + i, 31'd2);
        send_command(lobm_pkg::FUNC_ADD, lobm_pkg::SIDE_BID, 32'd1, 31'd1);
        send_command(lobm_pkg::FUNC_MATCH, 1'b0, '0, '0);
        send_command(lobm_pkg::FUNC_MATCH, 1'b0, '0, '0);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 87;
                2: sender_idle_pct = 25;
                default: sender_idle_pct = 0;
            endcase
            for (int n = 0; n < 125; n++)
            begin
                if (n % 40 == 0)
                    price_base = (ph == 3) ? 32'hFFFF_FFE0 : $urandom_range(0, 100000);
                random_command();
            end
        end
        start <= 1'b0;

        while (book.pending_results.size() != 0)
            @(posedge clk);
        repeat (4 * LEVELS + 20) @(posedge clk);
        if (book.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
